[hw/rtl/tgr_pkg.sv]
// ----------------------------------------------------------------------------
// tgr_pkg: shared types and codes for the text glyph row renderer
// Request codes, special character codes, beat structs and state encoding.
// ----------------------------------------------------------------------------
package tgr_pkg;

    // request codes
    localparam logic [2:0] REQ_PLACE       = 3'd0;
    localparam logic [2:0] REQ_NARROW      = 3'd1;
    localparam logic [2:0] REQ_WIDE        = 3'd2;
    localparam logic [2:0] REQ_LOAD_NARROW = 3'd3;
    localparam logic [2:0] REQ_LOAD_WIDE   = 3'd4;

    // character codes that only move the cursor
    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    // screen width after reset
    localparam logic [11:0] SCREEN_WIDTH_RST = 12'd480;

    // index of the sixteenth glyph row
    localparam logic [3:0] LAST_ROW_IDX = 4'd15;

    typedef enum logic {
        ST_IDLE,
        ST_DRAW
    } tgr_state_t;

    // input beat
    typedef struct packed {
        logic [2:0]  req_type;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [7:0]  char_code;
        logic [31:0] color;
        logic [12:0] font_addr;
        logic [7:0]  font_byte;
    } tgr_req_t;

    // output beat, one glyph row
    typedef struct packed {
        logic [11:0] row_x;
        logic [11:0] row_y;
        logic [15:0] row_bits;
        logic        wide_row;
        logic [31:0] row_color;
        logic        last_row;
    } tgr_row_t;

endpackage

[hw/rtl/tgr_ram.sv]
// ----------------------------------------------------------------------------
// tgr_ram: generic simple dual-port ram
// One write port, one read port, read data registered and held while idle.
// ----------------------------------------------------------------------------
module tgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, output holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/text_glyph_row_renderer_unit.sv]
// ----------------------------------------------------------------------------
// text_glyph_row_renderer_unit: text mode character generator, 8x16 / 16x16
// Turns a stream of requests into glyph pixel rows and keeps a text cursor.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one request per beat: place cursor,
//   narrow char, wide char, load narrow font byte, load wide font byte.
//   out_valid/out_ready/out_data carry one glyph row per beat, 16 beats
//   per drawn character, top row first, last_row set on the sixteenth.
//   cfg_wr_en/cfg_wr_data write screen_width; write it only while idle.
// Request handling:
//   place, line feed, carriage return and font loads leave the input ready
//   for the next request. A drawn character holds the input closed while its
//   sixteen glyph rows are read one at a time through the single read port of
//   the font memories, then the read stage and output register hold each row.
// Stalls:
//   a stalled receiver holds the output register; the row read behind it
//   waits in the ram output and row reads pause, nothing is dropped.
//   The input stays closed until the sixteenth row read has issued.
// Reset:
//   cursor goes to 0,0 and screen_width to 480. Font memories are not
//   cleared; a glyph must be loaded before it is drawn.
// ----------------------------------------------------------------------------
module text_glyph_row_renderer_unit
    import tgr_pkg::*;
#(
    parameter int NARROW_GLYPHS = 256,
    parameter int WIDE_GLYPHS   = 256,
    parameter int COORD_BITS    = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tgr_req_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output tgr_row_t    out_data,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data
);

    localparam int NARROW_DEPTH = NARROW_GLYPHS * 16;
    localparam int WIDE_DEPTH   = WIDE_GLYPHS * 16;
    localparam int NARROW_BYTES = NARROW_GLYPHS * 16;
    localparam int WIDE_BYTES   = WIDE_GLYPHS * 32;
    localparam int N_AW         = $clog2(NARROW_DEPTH);
    localparam int W_AW         = $clog2(WIDE_DEPTH);
    localparam int CW           = COORD_BITS;

    // state and registers
    tgr_state_t     state_reg, state_next;
    logic [3:0]     row_cnt_reg, row_cnt_next;
    logic [CW-1:0]  cur_x_reg, cur_x_next;
    logic [CW-1:0]  cur_y_reg, cur_y_next;
    logic [11:0]    sw_reg;
    logic [7:0]     job_code_reg, job_code_next;
    logic           job_wide_reg, job_wide_next;
    logic [31:0]    job_color_reg, job_color_next;
    logic           s1_vld_reg;
    logic           s1_oob_reg;
    tgr_row_t       s1_row_reg, s1_row_next;
    logic           out_vld_reg;
    tgr_row_t       out_row_reg, out_row_next;

    // control
    logic           acc;
    logic           draw_start;
    logic           rd_issue;
    logic           last_issue;
    logic           out_free;
    logic           s1_move;
    logic           s1_free;
    logic           issue_oob;

    // coordinate arithmetic
    logic [CW:0]    y_row_sum;
    logic [CW-1:0]  y_row_sat;
    logic [CW:0]    y_lf_sum;
    logic [CW-1:0]  y_lf_sat;
    logic [CW:0]    x_adv;
    logic           x_wrap;
    logic [15:0]    cx16;
    logic [15:0]    cy16;
    logic [15:0]    px16;
    logic [15:0]    py16;

    // font memory ports
    logic           nf_we;
    logic           wf_we_even;
    logic           wf_we_odd;
    logic [11:0]    glyph_idx;
    logic [11:0]    wide_load_idx;
    logic [7:0]     nf_rd;
    logic [7:0]     wf_rd_even;
    logic [7:0]     wf_rd_odd;
    logic [15:0]    s1_bits;

    // handshake bookkeeping
    assign acc        = in_valid && in_ready;
    assign out_free   = !out_vld_reg || out_ready;
    assign s1_move    = s1_vld_reg && out_free;
    assign s1_free    = !s1_vld_reg || s1_move;
    assign last_issue = rd_issue && (row_cnt_reg == LAST_ROW_IDX);
    assign draw_start = acc
                        && ((in_data.req_type == REQ_NARROW)
                            || (in_data.req_type == REQ_WIDE))
                        && (in_data.char_code != CHAR_LF)
                        && (in_data.char_code != CHAR_CR);

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (draw_start)
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (last_issue)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_ready = 1'b0;
        rd_issue = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_DRAW: rd_issue = s1_free;
            default: ;
        endcase
    end

    // cursor sums: y sums saturate, x advance checks for wrap
    assign y_row_sum = {1'b0, cur_y_reg} + (CW + 1)'(row_cnt_reg);
    assign y_row_sat = y_row_sum[CW] ? '1 : y_row_sum[CW-1:0];
    assign y_lf_sum  = {1'b0, cur_y_reg} + (CW + 1)'(16);
    assign y_lf_sat  = y_lf_sum[CW] ? '1 : y_lf_sum[CW-1:0];
    assign x_adv     = {1'b0, cur_x_reg} + (job_wide_reg ? (CW + 1)'(16) : (CW + 1)'(8));
    assign x_wrap    = x_adv[CW] || (17'(x_adv) >= 17'(sw_reg));

    // coordinates to and from the 12-bit fields
    assign cx16 = 16'(cur_x_reg);
    assign cy16 = 16'(y_row_sat);
    assign px16 = 16'(in_data.pos_x);
    assign py16 = 16'(in_data.pos_y);

    // request decode, cursor and job update
    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        row_cnt_next   = row_cnt_reg;
        job_code_next  = job_code_reg;
        job_wide_next  = job_wide_reg;
        job_color_next = job_color_reg;
        nf_we          = 1'b0;
        wf_we_even     = 1'b0;
        wf_we_odd      = 1'b0;
        if (acc)
        begin
            unique case (in_data.req_type) inside
                REQ_PLACE:
                begin
                    cur_x_next = px16[CW-1:0];
                    cur_y_next = py16[CW-1:0];
                end
                REQ_NARROW, REQ_WIDE:
                begin
                    if (in_data.char_code == CHAR_LF)
                    begin
                        cur_y_next = y_lf_sat;
                    end
                    else if (in_data.char_code == CHAR_CR)
                    begin
                        cur_x_next = '0;
                    end
                    else
                    begin
                        job_code_next  = in_data.char_code;
                        job_wide_next  = (in_data.req_type == REQ_WIDE);
                        job_color_next = in_data.color;
                        row_cnt_next   = '0;
                    end
                end
                REQ_LOAD_NARROW:
                begin
                    nf_we = (14'(in_data.font_addr) < 14'(NARROW_BYTES));
                end
                REQ_LOAD_WIDE:
                begin
                    wf_we_even = (14'(in_data.font_addr) < 14'(WIDE_BYTES))
                                 && !in_data.font_addr[0];
                    wf_we_odd  = (14'(in_data.font_addr) < 14'(WIDE_BYTES))
                                 && in_data.font_addr[0];
                end
                default: ;
            endcase
        end
        if (rd_issue)
        begin
            row_cnt_next = row_cnt_reg + 4'd1;
            if (last_issue)
            begin
                if (x_wrap)
                begin
                    cur_x_next = '0;
                    cur_y_next = y_lf_sat;
                end
                else
                begin
                    cur_x_next = x_adv[CW-1:0];
                end
            end
        end
    end

    // glyph row address and range check
    assign glyph_idx     = {job_code_reg, row_cnt_reg};
    assign wide_load_idx = in_data.font_addr[12:1];
    assign issue_oob     = job_wide_reg ? (9'({1'b0, job_code_reg}) >= 9'(WIDE_GLYPHS))
                                        : (9'({1'b0, job_code_reg}) >= 9'(NARROW_GLYPHS));

    // row metadata that travels with the read
    always_comb
    begin
        s1_row_next           = s1_row_reg;
        if (rd_issue)
        begin
            s1_row_next.row_x     = cx16[11:0];
            s1_row_next.row_y     = cy16[11:0];
            s1_row_next.row_bits  = '0;
            s1_row_next.wide_row  = job_wide_reg;
            s1_row_next.row_color = job_color_reg;
            s1_row_next.last_row  = (row_cnt_reg == LAST_ROW_IDX);
        end
    end

    // narrow font memory
    tgr_ram #(
        .WIDTH (8),
        .DEPTH (NARROW_DEPTH)
    ) u_narrow_ram (
        .clk     (clk),
        .wr_en   (nf_we),
        .wr_addr (in_data.font_addr[N_AW-1:0]),
        .wr_data (in_data.font_byte),
        .rd_en   (rd_issue),
        .rd_addr (glyph_idx[N_AW-1:0]),
        .rd_data (nf_rd)
    );

    // wide font, left byte bank
    tgr_ram #(
        .WIDTH (8),
        .DEPTH (WIDE_DEPTH)
    ) u_wide_even_ram (
        .clk     (clk),
        .wr_en   (wf_we_even),
        .wr_addr (wide_load_idx[W_AW-1:0]),
        .wr_data (in_data.font_byte),
        .rd_en   (rd_issue),
        .rd_addr (glyph_idx[W_AW-1:0]),
        .rd_data (wf_rd_even)
    );

    // wide font, right byte bank
    tgr_ram #(
        .WIDTH (8),
        .DEPTH (WIDE_DEPTH)
    ) u_wide_odd_ram (
        .clk     (clk),
        .wr_en   (wf_we_odd),
        .wr_addr (wide_load_idx[W_AW-1:0]),
        .wr_data (in_data.font_byte),
        .rd_en   (rd_issue),
        .rd_addr (glyph_idx[W_AW-1:0]),
        .rd_data (wf_rd_odd)
    );

    // assemble the row bits from the ram output
    always_comb
    begin
        if (s1_oob_reg)
        begin
            s1_bits = '0;
        end
        else if (s1_row_reg.wide_row)
        begin
            s1_bits = {wf_rd_even, wf_rd_odd};
        end
        else
        begin
            s1_bits = {8'h00, nf_rd};
        end
    end

    // output register load
    always_comb
    begin
        out_row_next = out_row_reg;
        if (s1_move)
        begin
            out_row_next          = s1_row_reg;
            out_row_next.row_bits = s1_bits;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_cnt_reg <= '0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            sw_reg      <= SCREEN_WIDTH_RST;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            if (cfg_wr_en)
            begin
                sw_reg <= cfg_wr_data;
            end
            s1_vld_reg  <= rd_issue || (s1_vld_reg && !s1_move);
            out_vld_reg <= s1_move || (out_vld_reg && !out_ready);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        job_code_reg  <= job_code_next;
        job_wide_reg  <= job_wide_next;
        job_color_reg <= job_color_next;
        s1_row_reg    <= s1_row_next;
        out_row_reg   <= out_row_next;
        if (rd_issue)
        begin
            s1_oob_reg <= issue_oob;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_row_reg;

    // a waiting row read is neither lost nor overwritten
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && !s1_move |=> s1_vld_reg && $stable(s1_row_reg))
        else $error("row in read stage lost or changed while stalled");

    // the sixteenth row read ends the glyph
    a_glyph_end: assert property (@(posedge clk) disable iff (!rst_n)
        last_issue |=> (state_reg == ST_IDLE) && (row_cnt_reg == 4'd0))
        else $error("glyph did not end after sixteen row reads");

    // cursor holds while a glyph is being read
    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW) && !last_issue |=> $stable(cur_x_reg) && $stable(cur_y_reg))
        else $error("cursor moved in the middle of a glyph");

    // read stage fills only from a row read
    a_s1_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s1_vld_reg) |-> $past(rd_issue))
        else $error("read stage valid without a row read");

endmodule
